// ----- hw/rtl/indexed_texture_to_argb4444_unit_macros.svh -----
// Assertion macros shared by the checker of the texture expansion unit.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef INDEXED_TEXTURE_TO_ARGB4444_UNIT_MACROS_SVH
`define INDEXED_TEXTURE_TO_ARGB4444_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define ITEX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted
`define ITEX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/itex_pkg.sv -----
// Shared types and constants of the indexed texture to ARGB4444 unit.
// No dependencies; used by every module of the unit.
`default_nettype none

package itex_pkg;

	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int COLOR_W           = 12;
	localparam int PIXEL_W           = 16;
	localparam int ALPHA_W           = 4;
	localparam int COUNT_W           = 2;
	localparam int RUN_W             = 5;

	// Item kinds carried on the mode field
	localparam logic MODE_PALETTE = 1'b0;
	localparam logic MODE_PIXEL   = 1'b1;

	// Pixel counts of a result
	localparam logic [COUNT_W-1:0] COUNT_ONE = 2'd1;
	localparam logic [COUNT_W-1:0] COUNT_TWO = 2'd2;

	// Pixel packing formats; the fourth code is unused
	typedef enum logic [1:0] {
		FMT_RAW    = 2'd0,
		FMT_PAIR   = 2'd1,
		FMT_PACKED = 2'd2
	} fmt_t;

	// Per-lane control handed from the decode stage to a lane
	typedef struct packed {
		logic               en;
		logic               use_raw;
		logic               hit;
		logic [ALPHA_W-1:0] alpha;
		logic [PIXEL_W-1:0] raw;
	} lane_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/indexed_texture_to_argb4444_unit.sv -----
// Top level of the indexed texture to ARGB4444 unit: decode, palette, two lanes, merge.
// Depends on itex_pkg, itex_palette and itex_lane.
//
//  channel | handshake            | carries
//  --------+----------------------+------------------------------------------------
//  cfg     | cfg_valid/cfg_ready  | cfg_data: pack_format
//  in      | in_valid/in_ready    | mode, entry_index, red..blue, indices, codes, raw
//  out     | out_valid/out_ready  | first_pixel, second_pixel, pixel_count
//
// One transaction per cycle while the output is not stalled; a result passes the
// registered palette read followed by the output register.
// Reset clears the format, run counter and valid flags; palette contents stay undefined.
// A stalled output holds its result while one more transaction is taken into stage 1.
`default_nettype none

module indexed_texture_to_argb4444_unit #(
	parameter int PALETTE_DEPTH = itex_pkg::PALETTE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [7:0]  entry_index,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  index_first,
	input  wire logic [7:0]  index_second,
	input  wire logic [7:0]  alpha_pair,
	input  wire logic [7:0]  packed_code,
	input  wire logic [15:0] raw_pixel,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      first_pixel,
	output logic [15:0]      second_pixel,
	output logic [1:0]       pixel_count
);

	localparam int         AW        = $clog2(PALETTE_DEPTH);
	localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

	itex_pkg::fmt_t                     fmt_q;
	logic [itex_pkg::RUN_W-1:0]         run_q;
	logic                               take;
	logic                               s2_free;

	logic [4:0]                         pk_idx;
	logic [2:0]                         pk_alpha;
	logic                               run_load;
	logic                               run_active;
	logic                               has_result;
	logic [itex_pkg::COUNT_W-1:0]       cnt;
	logic [7:0]                         rd_a;
	logic [7:0]                         rd_b;
	itex_pkg::lane_ctl_t                ctl_a;
	itex_pkg::lane_ctl_t                ctl_b;
	logic                               pal_we;

	logic                               valid_s1;
	itex_pkg::lane_ctl_t                ctl_a_s1;
	itex_pkg::lane_ctl_t                ctl_b_s1;
	logic [itex_pkg::COUNT_W-1:0]       cnt_s1;
	logic [itex_pkg::COLOR_W-1:0]       color_a;
	logic [itex_pkg::COLOR_W-1:0]       color_b;
	logic [itex_pkg::PIXEL_W-1:0]       pix_a;
	logic [itex_pkg::PIXEL_W-1:0]       pix_b;

	logic                               valid_s2;
	logic [itex_pkg::PIXEL_W-1:0]       first_s2;
	logic [itex_pkg::PIXEL_W-1:0]       second_s2;
	logic [itex_pkg::COUNT_W-1:0]       cnt_s2;

	// Flow control across the two stages
	assign cfg_ready = 1'b1;
	assign s2_free   = !valid_s2 || out_ready;
	assign in_ready  = !valid_s1 || s2_free;
	assign take      = in_valid && in_ready;

	// Format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= itex_pkg::FMT_RAW;
		end else if (cfg_valid) begin
			fmt_q <= itex_pkg::fmt_t'(cfg_data);
		end
	end

	// Decode the incoming transaction into lane controls
	assign pk_idx     = packed_code[7:3];
	assign pk_alpha   = packed_code[2:0];
	assign run_active = (run_q != '0);
	assign run_load   = (fmt_q == itex_pkg::FMT_PACKED) && (pk_alpha == 3'd0) && (pk_idx != 5'd0);

	always_comb begin
		ctl_a      = '0;
		ctl_b      = '0;
		cnt        = itex_pkg::COUNT_ONE;
		rd_a       = index_first;
		rd_b       = index_second;
		has_result = 1'b0;
		case (fmt_q)
			itex_pkg::FMT_RAW: begin
				has_result    = 1'b1;
				ctl_a.en      = 1'b1;
				ctl_a.use_raw = 1'b1;
				ctl_a.raw     = raw_pixel;
			end
			itex_pkg::FMT_PAIR: begin
				has_result  = 1'b1;
				cnt         = itex_pkg::COUNT_TWO;
				ctl_a.en    = 1'b1;
				ctl_a.alpha = alpha_pair[7:4];
				ctl_a.hit   = ({1'b0, index_first} < DEPTH_LIM);
				ctl_b.en    = 1'b1;
				ctl_b.alpha = alpha_pair[3:0];
				ctl_b.hit   = ({1'b0, index_second} < DEPTH_LIM);
			end
			itex_pkg::FMT_PACKED: begin
				has_result  = !run_load;
				rd_a        = {3'd0, pk_idx};
				ctl_a.en    = 1'b1;
				ctl_a.alpha = {pk_alpha, run_active};
				ctl_a.hit   = ({4'd0, pk_idx} < DEPTH_LIM);
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
		if (mode != itex_pkg::MODE_PIXEL) begin
			has_result = 1'b0;
		end
	end

	// Load or count down the run counter on packed pixel transactions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (take && (mode == itex_pkg::MODE_PIXEL)
				&& (fmt_q == itex_pkg::FMT_PACKED)) begin
			if (run_load) begin
				run_q <= pk_idx;
			end else if (run_active) begin
				run_q <= run_q - 1'b1;
			end
		end
	end

	// Palette write and lane reads
	assign pal_we = take && (mode == itex_pkg::MODE_PALETTE) && ({1'b0, entry_index} < DEPTH_LIM);

	itex_palette #(
		.PALETTE_DEPTH(PALETTE_DEPTH),
		.AW           (AW)
	) u_palette (
		.clk    (clk),
		.we     (pal_we),
		.waddr  (entry_index[AW-1:0]),
		.wdata  ({red[7:4], green[7:4], blue[7:4]}),
		.re     (take),
		.raddr_a(rd_a[AW-1:0]),
		.raddr_b(rd_b[AW-1:0]),
		.rdata_a(color_a),
		.rdata_b(color_b)
	);

	// Stage 1 control, alongside the palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= take && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ctl_a_s1 <= ctl_a;
			ctl_b_s1 <= ctl_b;
			cnt_s1   <= cnt;
		end
	end

	// Pixel lanes
	itex_lane u_lane_a (
		.ctl  (ctl_a_s1),
		.color(color_a),
		.pixel(pix_a)
	);

	itex_lane u_lane_b (
		.ctl  (ctl_b_s1),
		.color(color_b),
		.pixel(pix_b)
	);

	// Merge lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && valid_s1) begin
			first_s2  <= pix_a;
			second_s2 <= pix_b;
			cnt_s2    <= cnt_s1;
		end
	end

	assign out_valid    = valid_s2;
	assign first_pixel  = first_s2;
	assign second_pixel = second_s2;
	assign pixel_count  = cnt_s2;

endmodule

`default_nettype wire

// ----- hw/rtl/itex_palette.sv -----
// Palette memory: one write port, two registered read ports.
// Depends on itex_pkg for the colour width.
`default_nettype none

module itex_palette #(
	parameter int PALETTE_DEPTH = itex_pkg::PALETTE_DEPTH_DEF,
	parameter int AW            = $clog2(PALETTE_DEPTH)
) (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [AW-1:0]               waddr,
	input  wire logic [itex_pkg::COLOR_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [AW-1:0]               raddr_a,
	input  wire logic [AW-1:0]               raddr_b,
	output logic      [itex_pkg::COLOR_W-1:0] rdata_a,
	output logic      [itex_pkg::COLOR_W-1:0] rdata_b
);

	logic [itex_pkg::COLOR_W-1:0] mem_q [PALETTE_DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read both lanes; hold data while no transaction is taken
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/itex_lane.sv -----
// One pixel lane: forms an ARGB4444 pixel from alpha, palette colour or raw word.
// Depends on itex_pkg for lane_ctl_t and widths.
`default_nettype none

module itex_lane (
	input  wire itex_pkg::lane_ctl_t          ctl,
	input  wire logic [itex_pkg::COLOR_W-1:0] color,
	output logic      [itex_pkg::PIXEL_W-1:0] pixel
);

	logic [itex_pkg::COLOR_W-1:0] color_eff;

	// Drop colour for an index past the palette end
	assign color_eff = ctl.hit ? color : '0;

	// Select raw word, palette pixel or zero for an idle lane
	always_comb begin
		if (!ctl.en) begin
			pixel = '0;
		end else if (ctl.use_raw) begin
			pixel = ctl.raw;
		end else begin
			pixel = {ctl.alpha, color_eff};
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/itex_checker.sv -----
// Port-level checker for the indexed texture to ARGB4444 unit, bound to the top level.
// Depends on the assertion macros header and itex_pkg for the pixel counts.
`default_nettype none

`include "indexed_texture_to_argb4444_unit_macros.svh"

module itex_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] first_pixel,
	input wire logic [15:0] second_pixel,
	input wire logic [1:0]  pixel_count
);

	// Hold a stalled result
	`ITEX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(first_pixel) && $stable(second_pixel) && $stable(pixel_count), "stalled result changed")

	// Count is one or two
	`ITEX_ASSERT_NOW(a_count_range, out_valid, pixel_count == itex_pkg::COUNT_ONE || pixel_count == itex_pkg::COUNT_TWO, "pixel count out of range")

	// Single-pixel results leave the second pixel zero
	`ITEX_ASSERT_NOW(a_second_zero, out_valid && pixel_count == itex_pkg::COUNT_ONE, second_pixel == 16'd0, "second pixel set in single-pixel result")

	// A new result follows a transaction taken at the input, registered through stage 1 and the output register
	`ITEX_ASSERT_NOW(a_result_source, $rose(out_valid), $past(in_valid && in_ready, 2), "result without input transaction")

endmodule

bind indexed_texture_to_argb4444_unit itex_checker u_itex_checker (.*);

`default_nettype wire
